// ===== src/code_lock_controller_core_defines.svh =====
// -----------------------------------------------------------------------------
// code_lock_controller_core_defines.svh
// Assertion macros used by the code lock controller core.
// -----------------------------------------------------------------------------
`ifndef CODE_LOCK_CONTROLLER_CORE_DEFINES_SVH
`define CODE_LOCK_CONTROLLER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, held off during reset
`define CLC_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, held off during reset
`define CLC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define CLC_ASSERT_IMPL(label, clk, rst_n, pre, post, msg)
`define CLC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)

`endif

`endif

// ===== src/clc_pkg.sv =====
// -----------------------------------------------------------------------------
// clc_pkg
// Types, register indexes and constants of the code lock controller.
// -----------------------------------------------------------------------------
`default_nettype none

package clc_pkg;

	// Entry length and derived digit counter width
	localparam int unsigned MAX_DIGITS = 6;
	localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);

	// Field widths
	localparam int unsigned CODE_W  = 20;
	localparam int unsigned STEPS_W = 16;
	localparam int unsigned DUTY_W  = 10;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned ACC_W   = CODE_W + 4;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_UNLOCK_CODE = 3'd0;
	localparam logic [IDX_W-1:0] REG_OPEN_STEPS  = 3'd1;
	localparam logic [IDX_W-1:0] REG_DENY_STEPS  = 3'd2;
	localparam logic [IDX_W-1:0] REG_OPEN_DUTY   = 3'd3;
	localparam logic [IDX_W-1:0] REG_CLOSED_DUTY = 3'd4;

	// Register reset values
	localparam logic [CODE_W-1:0]  RESET_UNLOCK_CODE = 20'd123456;
	localparam logic [STEPS_W-1:0] RESET_OPEN_STEPS  = 16'd500;
	localparam logic [STEPS_W-1:0] RESET_DENY_STEPS  = 16'd200;
	localparam logic [DUTY_W-1:0]  RESET_OPEN_DUTY   = 10'd75;
	localparam logic [DUTY_W-1:0]  RESET_CLOSED_DUTY = 10'd50;

	// Limits and characters
	localparam logic [DUTY_W-1:0] DUTY_MAX  = 10'd1000;
	localparam logic [CODE_W-1:0] VALUE_MAX = 20'hFFFFF;
	localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_0    = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_9    = 8'h39;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_ENTRY   = 2'd1,
		MODE_GRANTED = 2'd2,
		MODE_DENIED  = 2'd3
	} lock_mode_t;

	typedef struct packed {
		logic [CODE_W-1:0]  unlock_code;
		logic [STEPS_W-1:0] open_steps;
		logic [STEPS_W-1:0] deny_steps;
		logic [DUTY_W-1:0]  open_duty;
		logic [DUTY_W-1:0]  closed_duty;
	} cfg_t;

	typedef struct packed {
		logic              button_level;
		logic              byte_valid;
		logic [BYTE_W-1:0] rx_byte;
	} step_t;

	typedef struct packed {
		lock_mode_t        mode;
		logic              green_lamp;
		logic              red_lamp;
		logic [DUTY_W-1:0] servo_duty;
		logic              echo_star;
		logic              prompt_start;
	} res_t;

	function automatic logic [DUTY_W-1:0] clamp_duty(input logic [DUTY_W-1:0] d);
		return (d > DUTY_MAX) ? DUTY_MAX : d;
	endfunction

endpackage

`default_nettype wire

// ===== src/clc_step_if.sv =====
// -----------------------------------------------------------------------------
// clc_step_if
// Input channel: one control step per transaction.
// -----------------------------------------------------------------------------
`default_nettype none

interface clc_step_if;
	logic                      valid;
	logic                      ready;
	logic                      button_level;
	logic                      byte_valid;
	logic [clc_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, button_level, byte_valid, rx_byte, input ready);
	modport sink   (input valid, button_level, byte_valid, rx_byte, output ready);
endinterface

`default_nettype wire

// ===== src/clc_result_if.sv =====
// -----------------------------------------------------------------------------
// clc_result_if
// Output channel: lock status after each control step.
// -----------------------------------------------------------------------------
`default_nettype none

interface clc_result_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                mode;
	logic                      green_lamp;
	logic                      red_lamp;
	logic [clc_pkg::DUTY_W-1:0] servo_duty;
	logic                      echo_star;
	logic                      prompt_start;

	modport source (output valid, mode, green_lamp, red_lamp, servo_duty, echo_star,
		prompt_start, input ready);
	modport sink   (input valid, mode, green_lamp, red_lamp, servo_duty, echo_star,
		prompt_start, output ready);
endinterface

`default_nettype wire

// ===== src/clc_cfg_regs.sv =====
// -----------------------------------------------------------------------------
// clc_cfg_regs
// Configuration register file, written by index, no read-back.
// -----------------------------------------------------------------------------
`default_nettype none

module clc_cfg_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic [clc_pkg::IDX_W-1:0]   wr_index,
	input  wire logic [clc_pkg::CODE_W-1:0]  wr_data,
	output clc_pkg::cfg_t                    cfg
);

	clc_pkg::cfg_t cfg_q;

	// Register writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unlock_code <= clc_pkg::RESET_UNLOCK_CODE;
			cfg_q.open_steps  <= clc_pkg::RESET_OPEN_STEPS;
			cfg_q.deny_steps  <= clc_pkg::RESET_DENY_STEPS;
			cfg_q.open_duty   <= clc_pkg::RESET_OPEN_DUTY;
			cfg_q.closed_duty <= clc_pkg::RESET_CLOSED_DUTY;
		end else if (wr_en) begin
			unique case (wr_index)
				clc_pkg::REG_UNLOCK_CODE: cfg_q.unlock_code <= wr_data;
				clc_pkg::REG_OPEN_STEPS:  cfg_q.open_steps  <= wr_data[clc_pkg::STEPS_W-1:0];
				clc_pkg::REG_DENY_STEPS:  cfg_q.deny_steps  <= wr_data[clc_pkg::STEPS_W-1:0];
				clc_pkg::REG_OPEN_DUTY:   cfg_q.open_duty   <= wr_data[clc_pkg::DUTY_W-1:0];
				clc_pkg::REG_CLOSED_DUTY: cfg_q.closed_duty <= wr_data[clc_pkg::DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== src/clc_ctrl.sv =====
// -----------------------------------------------------------------------------
// clc_ctrl
// Lock state machine: mode, button history, digit entry and hold timer.
// Updates once per fired step and gives the status after that step.
// -----------------------------------------------------------------------------
`default_nettype none

module clc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           fire,
	input  wire clc_pkg::step_t item,
	input  wire clc_pkg::cfg_t  cfg,
	output clc_pkg::res_t       res
);

	clc_pkg::lock_mode_t              mode_q, mode_n;
	logic                             prev_button_q, prev_button_n;
	logic [clc_pkg::CNT_W-1:0]        digit_count_q, digit_count_n;
	logic [clc_pkg::CODE_W-1:0]       entered_value_q, entered_value_n;
	logic [clc_pkg::STEPS_W-1:0]      hold_q, hold_n;

	logic                             rising;
	logic                             is_end;
	logic                             is_digit;
	logic [3:0]                       digit;
	logic [clc_pkg::ACC_W-1:0]        acc;
	logic [clc_pkg::CODE_W-1:0]       acc_sat;
	logic [clc_pkg::CNT_W-1:0]        count_inc;
	logic                             code_match;
	logic                             line_match;

	// Decode of the step
	always_comb begin
		rising    = item.button_level && !prev_button_q;
		is_end    = (item.rx_byte == clc_pkg::CHAR_CR) || (item.rx_byte == clc_pkg::CHAR_LF);
		is_digit  = (item.rx_byte >= clc_pkg::CHAR_0) && (item.rx_byte <= clc_pkg::CHAR_9);
		digit     = 4'(item.rx_byte - clc_pkg::CHAR_0);
		// value * 10 + digit, saturated to the field width
		acc       = (clc_pkg::ACC_W'(entered_value_q) << 3)
			+ (clc_pkg::ACC_W'(entered_value_q) << 1) + clc_pkg::ACC_W'(digit);
		acc_sat   = (acc > clc_pkg::ACC_W'(clc_pkg::VALUE_MAX)) ? clc_pkg::VALUE_MAX
			: acc[clc_pkg::CODE_W-1:0];
		count_inc  = digit_count_q + clc_pkg::CNT_W'(1);
		line_match = (entered_value_q == cfg.unlock_code);
		code_match = (acc_sat == cfg.unlock_code);
	end

	// Next state
	always_comb begin
		mode_n          = mode_q;
		prev_button_n   = prev_button_q;
		digit_count_n   = digit_count_q;
		entered_value_n = entered_value_q;
		hold_n          = hold_q;
		if (fire) begin
			prev_button_n = item.button_level;
			unique case (mode_q)
				clc_pkg::MODE_IDLE: begin
					if (rising) begin
						mode_n          = clc_pkg::MODE_ENTRY;
						digit_count_n   = '0;
						entered_value_n = '0;
					end
				end
				clc_pkg::MODE_ENTRY: begin
					if (item.byte_valid) begin
						priority if (is_end && (digit_count_q != '0)) begin
							// line end closes entry with the digits so far
							mode_n          = line_match ? clc_pkg::MODE_GRANTED
								: clc_pkg::MODE_DENIED;
							hold_n          = line_match ? cfg.open_steps : cfg.deny_steps;
							digit_count_n   = '0;
							entered_value_n = '0;
						end else if (is_digit) begin
							if (count_inc >= clc_pkg::CNT_W'(clc_pkg::MAX_DIGITS)) begin
								// last digit closes entry
								mode_n          = code_match ? clc_pkg::MODE_GRANTED
									: clc_pkg::MODE_DENIED;
								hold_n          = code_match ? cfg.open_steps
									: cfg.deny_steps;
								digit_count_n   = '0;
								entered_value_n = '0;
							end else begin
								digit_count_n   = count_inc;
								entered_value_n = acc_sat;
							end
						end
					end
				end
				clc_pkg::MODE_GRANTED, clc_pkg::MODE_DENIED: begin
					// hold timer; zero acts as one
					if (hold_q <= clc_pkg::STEPS_W'(1)) begin
						hold_n = '0;
						mode_n = clc_pkg::MODE_IDLE;
					end else begin
						hold_n = hold_q - clc_pkg::STEPS_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Status after the step
	always_comb begin
		res.mode         = mode_n;
		res.green_lamp   = (mode_n == clc_pkg::MODE_GRANTED);
		res.red_lamp     = (mode_n == clc_pkg::MODE_DENIED);
		res.servo_duty   = (mode_n == clc_pkg::MODE_GRANTED)
			? clc_pkg::clamp_duty(cfg.open_duty) : clc_pkg::clamp_duty(cfg.closed_duty);
		res.echo_star    = fire && (mode_q == clc_pkg::MODE_ENTRY) && item.byte_valid && is_digit;
		res.prompt_start = fire && (mode_q == clc_pkg::MODE_IDLE) && rising;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= clc_pkg::MODE_IDLE;
			prev_button_q   <= 1'b0;
			digit_count_q   <= '0;
			entered_value_q <= '0;
			hold_q          <= '0;
		end else begin
			mode_q          <= mode_n;
			prev_button_q   <= prev_button_n;
			digit_count_q   <= digit_count_n;
			entered_value_q <= entered_value_n;
			hold_q          <= hold_n;
		end
	end

endmodule

`default_nettype wire

// ===== src/code_lock_controller_core.sv =====
// -----------------------------------------------------------------------------
// Code lock controller core.
// The step channel carries one control step per transaction: the debounced
// button level, a byte-present flag and the received byte. The result channel
// returns one status transaction per step: mode, lamps, servo duty and the
// echo and prompt pulses, showing the state after that step.
// The write port (wr_en, wr_index, wr_data) sets the unlock code, the open and
// deny hold lengths in steps, and the open and closed servo duties; write it
// only while no step is in flight.
// A step accepted into the input register is presented on the result channel
// once it is loaded into the result register. Throughput: one step per cycle;
// the input and result registers form a two-stage pipe that advances whenever
// the result register is empty or taken, so the state update sets the pace.
// When the receiver stalls, the result register holds, the input register
// still takes one more step, and then step.ready drops until the result moves.
// Reset puts the lock in idle with the door closed and loads the register
// defaults; no clearing pass is needed.
// -----------------------------------------------------------------------------
`default_nettype none

`include "code_lock_controller_core_defines.svh"

module code_lock_controller_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	clc_step_if.sink                         step,
	clc_result_if.source                     result,
	input  wire logic                        wr_en,
	input  wire logic [clc_pkg::IDX_W-1:0]   wr_index,
	input  wire logic [clc_pkg::CODE_W-1:0]  wr_data
);

	clc_pkg::cfg_t  cfg;
	clc_pkg::step_t item_s1;
	clc_pkg::res_t  res_next;
	clc_pkg::res_t  res_s2;
	logic           valid_s1;
	logic           valid_s2;
	logic           adv;
	logic           fire;

	// Pipe control
	assign adv        = !valid_s2 || result.ready;
	assign fire       = valid_s1 && adv;
	assign step.ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (step.ready) begin
			valid_s1 <= step.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step.ready && step.valid) begin
			item_s1.button_level <= step.button_level;
			item_s1.byte_valid   <= step.byte_valid;
			item_s1.rx_byte      <= step.rx_byte;
		end
	end

	clc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	clc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_next;
		end
	end

	assign result.valid        = valid_s2;
	assign result.mode         = res_s2.mode;
	assign result.green_lamp   = res_s2.green_lamp;
	assign result.red_lamp     = res_s2.red_lamp;
	assign result.servo_duty   = res_s2.servo_duty;
	assign result.echo_star    = res_s2.echo_star;
	assign result.prompt_start = res_s2.prompt_start;

	// Checks
	`CLC_ASSERT_IMPL(a_lamps_exclusive, clk, arst_n, valid_s2,
		!(res_s2.green_lamp && res_s2.red_lamp), "green and red lamp both on")
	`CLC_ASSERT_IMPL(a_prompt_mode, clk, arst_n, valid_s2 && res_s2.prompt_start,
		res_s2.mode == clc_pkg::MODE_ENTRY, "prompt without code entry")
	`CLC_ASSERT_IMPL(a_echo_mode, clk, arst_n, valid_s2 && res_s2.echo_star,
		res_s2.mode != clc_pkg::MODE_IDLE, "digit echo while idle")
	`CLC_ASSERT_NEXT(a_stall_holds_s1, clk, arst_n, valid_s1 && !adv,
		valid_s1 && $stable(item_s1), "stalled step lost from input register")

endmodule

`default_nettype wire

// ===== sim/code_lock_status_checker.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// code_lock_status_checker
// Watches the step channel, the status channel and the register write port.
// Keeps its own copy of the lock state and registers, works out the status
// for every accepted step and compares each status transaction, in order,
// with the oldest pending one.
// -----------------------------------------------------------------------------
module code_lock_status_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	clc_step_if                             step,
	clc_result_if                           result,
	input  wire logic                       wr_en,
	input  wire logic [clc_pkg::IDX_W-1:0]  wr_index,
	input  wire logic [clc_pkg::CODE_W-1:0] wr_data,
	output int                              outstanding,
	output int                              fail_count
);
	import clc_pkg::*;

	// Shadow registers and lock state
	cfg_t               regs;
	lock_mode_t         lock_state;
	logic               prev_level;
	logic [3:0]         digit_total;
	logic [CODE_W-1:0]  typed_value;
	logic [STEPS_W-1:0] hold_left;

	// Pending status transactions, oldest first
	res_t status_q[$];
	res_t want;
	int   status_seen;

	// Entry done: compare and start the hold
	function automatic void conclude_entry();
		if (typed_value == regs.unlock_code) begin
			lock_state = MODE_GRANTED;
			hold_left  = regs.open_steps;
		end else begin
			lock_state = MODE_DENIED;
			hold_left  = regs.deny_steps;
		end
		digit_total = '0;
		typed_value = '0;
	endfunction

	// One control step: update state, return the status after it
	function automatic res_t lock_step(input logic btn, input logic bv,
		input logic [BYTE_W-1:0] ch);
		res_t        r;
		logic        pressed;
		int unsigned acc;
		pressed    = btn && !prev_level;
		prev_level = btn;
		r          = '0;
		case (lock_state)
			MODE_IDLE: begin
				if (pressed) begin
					lock_state     = MODE_ENTRY;
					digit_total    = '0;
					typed_value    = '0;
					r.prompt_start = 1'b1;
				end
			end
			MODE_ENTRY: begin
				if (bv) begin
					if ((ch == CHAR_CR || ch == CHAR_LF) && digit_total != 0) begin
						conclude_entry();
					end else if (ch >= CHAR_0 && ch <= CHAR_9) begin
						acc         = typed_value * 10 + (ch - CHAR_0);
						typed_value = (acc > VALUE_MAX) ? VALUE_MAX : acc[CODE_W-1:0];
						r.echo_star = 1'b1;
						digit_total = digit_total + 1'b1;
						if (digit_total >= MAX_DIGITS)
							conclude_entry();
					end
				end
			end
			default: begin
				// hold of zero behaves as one
				if (hold_left <= 1) begin
					hold_left  = '0;
					lock_state = MODE_IDLE;
				end else begin
					hold_left = hold_left - 1'b1;
				end
			end
		endcase
		r.mode       = lock_state;
		r.green_lamp = (lock_state == MODE_GRANTED);
		r.red_lamp   = (lock_state == MODE_DENIED);
		if (lock_state == MODE_GRANTED)
			r.servo_duty = (regs.open_duty > DUTY_MAX) ? DUTY_MAX : regs.open_duty;
		else
			r.servo_duty = (regs.closed_duty > DUTY_MAX) ? DUTY_MAX : regs.closed_duty;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.unlock_code = RESET_UNLOCK_CODE;
			regs.open_steps  = RESET_OPEN_STEPS;
			regs.deny_steps  = RESET_DENY_STEPS;
			regs.open_duty   = RESET_OPEN_DUTY;
			regs.closed_duty = RESET_CLOSED_DUTY;
			lock_state       = MODE_IDLE;
			prev_level       = 1'b0;
			digit_total      = '0;
			typed_value      = '0;
			hold_left        = '0;
			status_q.delete();
			outstanding     <= 0;
		end else begin
			// register writes; unmapped indexes are dropped
			if (wr_en) begin
				case (wr_index)
					REG_UNLOCK_CODE: regs.unlock_code = wr_data;
					REG_OPEN_STEPS:  regs.open_steps  = wr_data[STEPS_W-1:0];
					REG_DENY_STEPS:  regs.deny_steps  = wr_data[STEPS_W-1:0];
					REG_OPEN_DUTY:   regs.open_duty   = wr_data[DUTY_W-1:0];
					REG_CLOSED_DUTY: regs.closed_duty = wr_data[DUTY_W-1:0];
					default: ;
				endcase
			end

			// step transaction: predict its status
			if (step.valid && step.ready)
				status_q.push_back(lock_step(step.button_level, step.byte_valid, step.rx_byte));

			// status transaction: compare with the oldest prediction
			if (result.valid && result.ready) begin
				if (status_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("status %0d arrived with no step pending", status_seen);
				end else begin
					want = status_q.pop_front();
					if (want.mode !== result.mode || want.green_lamp !== result.green_lamp ||
						want.red_lamp !== result.red_lamp ||
						want.servo_duty !== result.servo_duty ||
						want.echo_star !== result.echo_star ||
						want.prompt_start !== result.prompt_start) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("status %0d: expected mode %0d green %0b red %0b",
								status_seen, want.mode, want.green_lamp, want.red_lamp,
								" duty %0d echo %0b prompt %0b",
								want.servo_duty, want.echo_star, want.prompt_start);
							$display("status %0d: got      mode %0d green %0b red %0b",
								status_seen, result.mode, result.green_lamp, result.red_lamp,
								" duty %0d echo %0b prompt %0b",
								result.servo_duty, result.echo_star, result.prompt_start);
						end
					end
				end
				status_seen++;
			end
			outstanding <= status_q.size();
		end
	end

endmodule

// ===== sim/code_lock_controller_core_test.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// code_lock_controller_core_test
// Drives control steps and register writes into the code lock core and gives
// the verdict. Directed steps cover reset values, leading zeros, ignored
// bytes and edges, zero hold, duty clamping and the largest code; random
// code attempts, noise bursts and a long status hold-off follow.
// -----------------------------------------------------------------------------
module code_lock_controller_core_test;
	import clc_pkg::*;

	localparam int               STALL_LIMIT     = 2000;
	localparam int               HOLD_OFF_CYCLES = 200;
	localparam int               PHASE_ITEMS     = 200;
	localparam logic [IDX_W-1:0] REG_UNUSED      = 3'd7;

	logic              clk;
	logic              arst_n;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_index;
	logic [CODE_W-1:0] wr_data;

	int outstanding;
	int fail_count;
	int idle_cycles;
	int phase_items;

	bit send_gaps;
	bit recv_stalls;
	bit hold_off_req;
	bit hold_off_done;

	// code and hold lengths currently loaded
	logic [CODE_W-1:0] code_now;
	int unsigned       open_wait;
	int unsigned       deny_wait;

	clc_step_if   step_ch ();
	clc_result_if result_ch ();

	code_lock_controller_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	code_lock_status_checker status_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step_ch),
		.result      (result_ch),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Status receiver: random stall bursts, one long hold-off on request
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
				result_ch.ready <= 1'b1;
			end else if (recv_stalls && $urandom_range(0, 9) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (step_ch.valid && step_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Offer one step and wait until it is taken
	task automatic offer_step(input logic btn, input logic bv, input logic [BYTE_W-1:0] ch);
		int unsigned gap;
		if (send_gaps && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 12);
			step_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		step_ch.valid        <= 1'b1;
		step_ch.button_level <= btn;
		step_ch.byte_valid   <= bv;
		step_ch.rx_byte      <= ch;
		@(posedge clk);
		while (!step_ch.ready) @(posedge clk);
		phase_items++;
	endtask

	// Stop offering and wait for every pending status
	task automatic settle();
		step_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write all registers, with junk in the unused upper data bits
	task automatic load_config(input logic [CODE_W-1:0] code, input logic [STEPS_W-1:0] open_n,
		input logic [STEPS_W-1:0] deny_n, input logic [DUTY_W-1:0] open_d,
		input logic [DUTY_W-1:0] closed_d);
		logic [CODE_W-1:0] junk;
		junk = CODE_W'($urandom);
		wr_en    <= 1'b1;
		wr_index <= REG_UNLOCK_CODE;
		wr_data  <= code;
		@(posedge clk);
		wr_index <= REG_OPEN_STEPS;
		wr_data  <= {junk[19:16], open_n};
		@(posedge clk);
		wr_index <= REG_DENY_STEPS;
		wr_data  <= {junk[15:12], deny_n};
		@(posedge clk);
		wr_index <= REG_OPEN_DUTY;
		wr_data  <= {junk[9:0], open_d};
		@(posedge clk);
		wr_index <= REG_CLOSED_DUTY;
		wr_data  <= {junk[19:10], closed_d};
		@(posedge clk);
		// a write to an unmapped index must change nothing
		wr_index <= REG_UNUSED;
		wr_data  <= junk;
		@(posedge clk);
		wr_en <= 1'b0;
		code_now  = code;
		open_wait = (open_n == '0) ? 1 : {16'd0, open_n};
		deny_wait = (deny_n == '0) ? 1 : {16'd0, deny_n};
	endtask

	// Any byte that is neither a digit nor a line end
	function automatic logic [BYTE_W-1:0] stray_byte();
		logic [BYTE_W-1:0] ch;
		do
			ch = BYTE_W'($urandom);
		while ((ch >= CHAR_0 && ch <= CHAR_9) || ch == CHAR_CR || ch == CHAR_LF);
		return ch;
	endfunction

	// Button released, random bytes: holds out granted or denied
	task automatic wait_out(input int unsigned n);
		logic [BYTE_W-1:0] ch;
		repeat (n) begin
			ch = BYTE_W'($urandom);
			offer_step(1'b0, 1'($urandom_range(0, 1)), ch);
		end
	endtask

	// Press, type a code (right one, near miss or random), end it, hold out
	task automatic enter_code(input bit right);
		int unsigned       digit_q[$];
		int unsigned       v;
		int unsigned       pos;
		logic [BYTE_W-1:0] ch;
		if (right || $urandom_range(0, 1)) begin
			v = {12'd0, code_now};
			do begin
				digit_q.push_front(v % 10);
				v = v / 10;
			end while (v != 0);
			while (digit_q.size() < MAX_DIGITS && $urandom_range(0, 2) == 0)
				digit_q.push_front(0);
			if (!right) begin
				pos          = $urandom_range(0, digit_q.size() - 1);
				digit_q[pos] = (digit_q[pos] + $urandom_range(1, 9)) % 10;
			end
		end else begin
			repeat ($urandom_range(1, MAX_DIGITS))
				digit_q.push_back($urandom_range(0, 9));
		end

		ch = BYTE_W'($urandom);
		offer_step(1'b0, 1'($urandom_range(0, 1)), ch);
		ch = BYTE_W'($urandom);
		offer_step(1'b1, 1'($urandom_range(0, 1)), ch);
		foreach (digit_q[i]) begin
			if ($urandom_range(0, 4) == 0)
				offer_step(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), stray_byte());
			v  = digit_q[i];
			ch = CHAR_0 + v[7:0];
			offer_step(1'($urandom_range(0, 1)), 1'b1, ch);
		end
		if (digit_q.size() < MAX_DIGITS)
			offer_step(1'($urandom_range(0, 1)), 1'b1,
				$urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
		wait_out((right ? open_wait : deny_wait) + $urandom_range(1, 3));
	endtask

	// Random steps biased toward digits, then force the lock back to idle
	task automatic scramble();
		int unsigned       pick;
		int unsigned       v;
		logic [BYTE_W-1:0] ch;
		repeat ($urandom_range(4, 16)) begin
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				v  = $urandom_range(0, 9);
				ch = CHAR_0 + v[7:0];
			end else if (pick == 4) begin
				ch = $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
			end else begin
				ch = BYTE_W'($urandom);
			end
			offer_step(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), ch);
		end
		offer_step(1'b0, 1'b1, CHAR_0);
		offer_step(1'b0, 1'b1, CHAR_CR);
		wait_out(((open_wait > deny_wait) ? open_wait : deny_wait) + 2);
	endtask

	// Random attempts until the phase has enough steps
	task automatic run_phase(input int target, input bit idling, input bit with_hold_off);
		int unsigned pick;
		phase_items = 0;
		send_gaps   = idling;
		recv_stalls = idling;
		while (phase_items < target) begin
			if (idling && $urandom_range(0, 5) == 0) begin
				send_gaps   = 1'($urandom_range(0, 1));
				recv_stalls = 1'($urandom_range(0, 1));
			end
			if (with_hold_off && !hold_off_done && phase_items >= target / 2) begin
				hold_off_req  = 1'b1;
				hold_off_done = 1'b1;
			end
			pick = $urandom_range(0, 9);
			if (pick < 2)
				scramble();
			else
				enter_code(pick < 6);
		end
	endtask

	// Stimulus
	initial begin
		arst_n               = 1'b0;
		wr_en                = 1'b0;
		wr_index             = '0;
		wr_data              = '0;
		step_ch.valid        = 1'b0;
		step_ch.button_level = 1'b0;
		step_ch.byte_valid   = 1'b0;
		step_ch.rx_byte      = '0;
		send_gaps            = 1'b1;
		recv_stalls          = 1'b1;
		hold_off_req         = 1'b0;
		hold_off_done        = 1'b0;
		code_now             = RESET_UNLOCK_CODE;
		open_wait            = {16'd0, RESET_OPEN_STEPS};
		deny_wait            = {16'd0, RESET_DENY_STEPS};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values: idle, then the default code and a wrong one
		offer_step(1'b0, 1'b0, 8'h00);
		offer_step(1'b0, 1'b1, 8'hFF);
		enter_code(1'b1);
		enter_code(1'b0);
		settle();

		// zero open hold, one-step deny, open duty above range
		load_config(20'd42, 16'd0, 16'd1, 10'd1023, 10'd1000);
		offer_step(1'b1, 1'b1, CHAR_0 + 8'd5);   // press; byte dropped
		offer_step(1'b1, 1'b1, CHAR_CR);         // no digits yet: ignored
		offer_step(1'b0, 1'b1, CHAR_LF);
		offer_step(1'b1, 1'b1, CHAR_9 + 8'd1);   // edge in entry, non-digit
		offer_step(1'b0, 1'b1, CHAR_0 - 8'd1);
		offer_step(1'b0, 1'b1, CHAR_0);          // leading zeros
		offer_step(1'b0, 1'b0, CHAR_0 + 8'd7);   // no byte this step
		offer_step(1'b0, 1'b1, CHAR_0);
		offer_step(1'b0, 1'b1, CHAR_0 + 8'd4);
		offer_step(1'b0, 1'b1, CHAR_0 + 8'd2);
		offer_step(1'b0, 1'b1, CHAR_CR);         // 0042 matches
		offer_step(1'b1, 1'b1, CHAR_0 + 8'd1);   // granted: edge and byte ignored
		offer_step(1'b1, 1'b0, 8'h00);           // no edge, button still held
		offer_step(1'b0, 1'b0, 8'h00);
		offer_step(1'b1, 1'b1, CHAR_9);
		repeat (6)
			offer_step(1'b0, 1'b1, CHAR_9);      // sixth digit ends entry
		offer_step(1'b0, 1'b1, CHAR_0 + 8'd3);   // denied: byte dropped
		offer_step(1'b0, 1'b1, 8'hFF);
		settle();

		// largest code, full-range duties, no idling
		load_config(20'd999999, 16'd6, 16'd4, 10'd1000, 10'd0);
		send_gaps   = 1'b0;
		recv_stalls = 1'b0;
		enter_code(1'b1);
		enter_code(1'b0);
		settle();

		// random attempts under several settings
		load_config(CODE_W'($urandom_range(0, 999999)), STEPS_W'($urandom_range(1, 8)),
			STEPS_W'($urandom_range(1, 8)), DUTY_W'($urandom_range(0, 1000)),
			DUTY_W'($urandom_range(0, 1000)));
		run_phase(PHASE_ITEMS, 1'b1, 1'b1);
		settle();

		load_config(20'd0, STEPS_W'($urandom_range(1, 4)), STEPS_W'($urandom_range(1, 4)),
			10'd0, 10'd1000);
		run_phase(PHASE_ITEMS, 1'b1, 1'b0);
		settle();

		// last part runs with no idling on either side
		load_config(CODE_W'($urandom_range(0, 999)), STEPS_W'($urandom_range(1, 8)),
			STEPS_W'($urandom_range(1, 8)), DUTY_W'($urandom_range(0, 1000)),
			DUTY_W'($urandom_range(0, 1000)));
		run_phase(PHASE_ITEMS, 1'b0, 1'b0);
		settle();
		repeat (6) @(posedge clk);

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/clc_pkg.sv
src/clc_step_if.sv
src/clc_result_if.sv
src/clc_cfg_regs.sv
src/clc_ctrl.sv
src/code_lock_controller_core.sv
sim/code_lock_status_checker.sv
sim/code_lock_controller_core_test.sv
